// ----- rtl/core/bci_pkg.sv -----
// shared types, widths and codes for the breakpoint curve interpolator
// no dependencies
`timescale 1ns / 1ps

package bci_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int POS_W          = 32;
	localparam int LVL_W          = 17;
	localparam int IDX_W          = 6;
	localparam int CNT_W          = 7;
	localparam int CFG_W          = 17;
	localparam int CFG_IDX_W      = 1;
	localparam int DEN_W          = POS_W + 1;
	localparam int PROD_W         = POS_W + LVL_W;
	localparam int DIV_STEPS      = LVL_W;
	localparam int DCNT_W         = 5;

	localparam logic [LVL_W-1:0] LEVEL_ONE = 17'd65536;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK    = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DINIT,
		ST_DIV,
		ST_SUM,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic write;
		logic step;
		logic load_fb;
		logic load_last;
		logic setup;
		logic mul;
		logic div_init;
		logic div_step;
		logic load_interp;
		logic out_load;
	} bci_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic below;
		logic first;
		logic last;
		logic div_done;
		logic out_free;
	} bci_status_t;

	function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] v);
		clamp_level = (v > LEVEL_ONE) ? LEVEL_ONE : v;
	endfunction

endpackage

// ----- rtl/core/breakpoint_curve_interpolator_top.sv -----
// Piecewise linear curve over a table of up to MAX_POINTS breakpoints. A write word
// stores one breakpoint and gives no result. A query word scans the table one stored
// point per cycle through the single read port of the table, then runs one 32x17
// multiply and a 17-step bit-serial divide for the fraction when it lands inside a
// segment; a query at or beyond the last of n points takes the level of that point,
// and one below the first point or with a point count of zero takes the fallback.
// One word is in work at a time; a finished result waits in the output register
// while the next word is taken.
// depends on bci_pkg, bci_ctrl, bci_dp
`timescale 1ns / 1ps

module breakpoint_curve_interpolator_top #(
	parameter int MAX_POINTS = bci_pkg::MAX_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [bci_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bci_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [bci_pkg::IDX_W-1:0]        point_index,
	input  logic signed [bci_pkg::POS_W-1:0] position,
	input  logic [bci_pkg::LVL_W-1:0]        level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bci_pkg::LVL_W-1:0]        curve_level,
	output logic                             used_fallback
);

	bci_pkg::bci_cmd_t    cmd;
	bci_pkg::bci_status_t status;

	bci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	bci_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.point_index   (point_index),
		.position      (position),
		.level         (level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.curve_level   (curve_level),
		.used_fallback (used_fallback)
	);

endmodule

// ----- rtl/core/bci_ctrl.sv -----
// controller state machine for the breakpoint curve interpolator
// depends on bci_pkg
`timescale 1ns / 1ps

module bci_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  command,
	input  bci_pkg::bci_status_t  status,
	output logic                  in_stall,
	output bci_pkg::bci_cmd_t     cmd
);

	bci_pkg::state_t state_q;
	bci_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bci_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bci_pkg::ST_IDLE: begin
				if (in_valid && command == bci_pkg::CMD_QUERY) begin
					state_next = status.n_zero ? bci_pkg::ST_FIN : bci_pkg::ST_SCAN;
				end
			end
			bci_pkg::ST_SCAN: begin
				if (status.below) begin
					state_next = status.first ? bci_pkg::ST_FIN : bci_pkg::ST_MUL;
				end else if (status.last) begin
					state_next = bci_pkg::ST_FIN;
				end
			end
			bci_pkg::ST_MUL:   state_next = bci_pkg::ST_DINIT;
			bci_pkg::ST_DINIT: state_next = bci_pkg::ST_DIV;
			bci_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_next = bci_pkg::ST_SUM;
				end
			end
			bci_pkg::ST_SUM:   state_next = bci_pkg::ST_FIN;
			bci_pkg::ST_FIN: begin
				if (status.out_free) begin
					state_next = bci_pkg::ST_IDLE;
				end
			end
			default: state_next = bci_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			bci_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (command == bci_pkg::CMD_QUERY) begin
						cmd.start   = ~status.n_zero;
						cmd.load_fb = status.n_zero;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			bci_pkg::ST_SCAN: begin
				if (status.below) begin
					cmd.load_fb = status.first;
					cmd.setup   = ~status.first;
				end else if (status.last) begin
					cmd.load_last = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			bci_pkg::ST_MUL:   cmd.mul         = 1'b1;
			bci_pkg::ST_DINIT: cmd.div_init    = 1'b1;
			bci_pkg::ST_DIV:   cmd.div_step    = 1'b1;
			bci_pkg::ST_SUM:   cmd.load_interp = 1'b1;
			bci_pkg::ST_FIN:   cmd.out_load    = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/core/bci_dp.sv -----
// datapath: config registers, breakpoint table, scan, multiply, serial divide, output register
// depends on bci_pkg
`timescale 1ns / 1ps

module bci_dp #(
	parameter int MAX_POINTS = bci_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bci_pkg::bci_cmd_t             cmd,
	output bci_pkg::bci_status_t          status,
	input  logic                          cfg_write,
	input  logic [bci_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bci_pkg::CFG_W-1:0]     cfg_data,
	input  logic [bci_pkg::IDX_W-1:0]     point_index,
	input  logic signed [bci_pkg::POS_W-1:0] position,
	input  logic [bci_pkg::LVL_W-1:0]     level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bci_pkg::LVL_W-1:0]     curve_level,
	output logic                          used_fallback
);

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int NW  = (CW > bci_pkg::CNT_W) ? CW : bci_pkg::CNT_W;
	localparam int WIW = bci_pkg::IDX_W + AW;
	localparam int MW  = bci_pkg::POS_W + bci_pkg::LVL_W;

	// config registers
	logic [bci_pkg::CNT_W-1:0] count_q;
	logic [bci_pkg::LVL_W-1:0] fallback_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			fallback_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bci_pkg::REG_POINT_COUNT: count_q    <= cfg_data[bci_pkg::CNT_W-1:0];
				bci_pkg::REG_FALLBACK:    fallback_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective point count
	logic [NW-1:0] cnt_ext;
	logic [NW-1:0] n_eff;

	always_comb begin
		cnt_ext = NW'(count_q);
		n_eff   = (cnt_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : cnt_ext;
	end

	// breakpoint table
	logic [MW-1:0]  mem [MAX_POINTS];
	logic [MW-1:0]  rd_q;
	logic [WIW-1:0] widx;
	logic           wr_en;
	logic [CW-1:0]  i_q;

	assign widx  = WIW'(point_index);
	assign wr_en = cmd.write && (widx < WIW'(MAX_POINTS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[widx[AW-1:0]] <= {position, bci_pkg::clamp_level(level)};
		end
		rd_q <= mem[i_q[AW-1:0]];
	end

	logic signed [bci_pkg::POS_W-1:0] rd_pos;
	logic [bci_pkg::LVL_W-1:0]        rd_lvl;

	assign rd_pos = $signed(rd_q[MW-1:bci_pkg::LVL_W]);
	assign rd_lvl = rd_q[bci_pkg::LVL_W-1:0];

	// scan registers
	logic signed [bci_pkg::POS_W-1:0] q_q;
	logic [CW-1:0]                    n_q;
	logic signed [bci_pkg::POS_W-1:0] prev_pos_q;
	logic [bci_pkg::LVL_W-1:0]        prev_lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (cmd.start) begin
			i_q <= CW'(1);
		end else if (cmd.step) begin
			i_q <= i_q + CW'(1);
		end else if (cmd.out_load) begin
			i_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q <= position;
			n_q <= CW'(n_eff);
		end
		if (cmd.step) begin
			prev_pos_q <= rd_pos;
			prev_lvl_q <= rd_lvl;
		end
	end

	// interpolation setup, multiply and restoring divide
	logic signed [bci_pkg::DEN_W-1:0] num_w;
	logic signed [bci_pkg::DEN_W-1:0] den_w;
	logic [bci_pkg::POS_W-1:0]        num_q;
	logic [bci_pkg::DEN_W-1:0]        den_q;
	logic [bci_pkg::LVL_W-1:0]        diff_q;
	logic [bci_pkg::LVL_W-1:0]        l0_q;
	logic                             down_q;
	logic [bci_pkg::PROD_W-1:0]       prod_q;
	logic [bci_pkg::DEN_W-1:0]        rem_q;
	logic [bci_pkg::LVL_W-1:0]        quo_q;
	logic [bci_pkg::DCNT_W-1:0]       dcnt_q;
	logic [bci_pkg::DEN_W:0]          trial;
	logic [bci_pkg::DEN_W:0]          trial_sub;
	logic                             trial_ge;

	assign num_w     = {q_q[bci_pkg::POS_W-1], q_q} - {prev_pos_q[bci_pkg::POS_W-1], prev_pos_q};
	assign den_w     = {rd_pos[bci_pkg::POS_W-1], rd_pos}
	                 - {prev_pos_q[bci_pkg::POS_W-1], prev_pos_q};
	assign trial     = {rem_q, quo_q[bci_pkg::LVL_W-1]};
	assign trial_ge  = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			num_q  <= num_w[bci_pkg::POS_W-1:0];
			den_q  <= den_w;
			l0_q   <= prev_lvl_q;
			down_q <= rd_lvl < prev_lvl_q;
			diff_q <= (rd_lvl < prev_lvl_q) ? (prev_lvl_q - rd_lvl) : (rd_lvl - prev_lvl_q);
		end
		if (cmd.mul) begin
			prod_q <= num_q * diff_q;
		end
		if (cmd.div_init) begin
			rem_q  <= {1'b0, prod_q[bci_pkg::PROD_W-1:bci_pkg::LVL_W]};
			quo_q  <= prod_q[bci_pkg::LVL_W-1:0];
			dcnt_q <= bci_pkg::DCNT_W'(bci_pkg::DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? trial_sub[bci_pkg::DEN_W-1:0] : trial[bci_pkg::DEN_W-1:0];
			quo_q  <= {quo_q[bci_pkg::LVL_W-2:0], trial_ge};
			dcnt_q <= dcnt_q - bci_pkg::DCNT_W'(1);
		end
	end

	// result and output register
	logic [bci_pkg::LVL_W-1:0] res_lvl_q;
	logic                      res_fb_q;
	logic                      out_valid_q;
	logic [bci_pkg::LVL_W-1:0] out_lvl_q;
	logic                      out_fb_q;

	always_ff @(posedge clk) begin
		if (cmd.load_fb) begin
			res_lvl_q <= bci_pkg::clamp_level(fallback_q);
			res_fb_q  <= 1'b1;
		end else if (cmd.load_last) begin
			res_lvl_q <= rd_lvl;
			res_fb_q  <= 1'b0;
		end else if (cmd.load_interp) begin
			res_lvl_q <= down_q ? (l0_q - quo_q) : (l0_q + quo_q);
			res_fb_q  <= 1'b0;
		end
		if (cmd.out_load) begin
			out_lvl_q <= res_lvl_q;
			out_fb_q  <= res_fb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign curve_level   = out_lvl_q;
	assign used_fallback = out_fb_q;

	always_comb begin
		status.n_zero   = (n_eff == '0);
		status.below    = q_q < rd_pos;
		status.first    = (i_q == CW'(1));
		status.last     = (i_q == n_q);
		status.div_done = (dcnt_q == '0);
		status.out_free = ~out_valid_q | ~out_stall;
	end

endmodule
